### design/rrsq_pkg.sv
// ============================================================================
// rrsq_pkg
// Shared types and codes for the round-robin service queue: request and
// result payloads, the queue entry, configuration registers and status codes.
// ============================================================================
`default_nettype none

package rrsq_pkg;

  // Operation codes carried in a request.
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_RUN     = 2'd2;
  localparam logic [1:0] OP_FIND    = 2'd3;

  // Status codes carried in a result.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_TIMEUP    = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // A run serves at most this many slices.
  localparam int unsigned    SLICE_CNT_W   = 6;
  localparam logic [5:0]     RUN_SLICE_CAP = 6'd63;

  // Configuration register indexes and reset values.
  localparam logic REG_MAX_ORDERS   = 1'b0;
  localparam logic REG_SLICE_LENGTH = 1'b1;
  localparam logic [7:0]  MAX_ORDERS_RST   = 8'd3;
  localparam logic [11:0] SLICE_LENGTH_RST = 12'd60;

  // Request payload.
  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  driver_id;
    logic [9:0]  rating;
    logic [7:0]  orders_done;
    logic [11:0] time_budget;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_id;
    logic [9:0] out_rating;
    logic [7:0] out_orders;
    logic       retired;
    logic [3:0] position;
    logic [4:0] entry_count;
    logic       last;
  } res_t;

  // One stored queue entry.
  typedef struct packed {
    logic [7:0] id;
    logic [9:0] rating;
    logic [7:0] orders;
  } entry_t;

  // Configuration register values.
  typedef struct packed {
    logic [7:0]  max_orders;
    logic [11:0] slice_length;
  } cfg_t;

endpackage

`default_nettype wire

### design/rrsq_cfg_regs.sv
// ============================================================================
// rrsq_cfg_regs
// APB-style register file holding the retire threshold and the slice length.
// ============================================================================
`default_nettype none

module rrsq_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output rrsq_pkg::cfg_t     cfg_o
);
  import rrsq_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic reg_idx;
  logic wr_en;

  // Registers sit at byte addresses 0 and 4.
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register update on the access phase of a write.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_ORDERS:   cfg_d.max_orders   = pwdata[7:0];
        REG_SLICE_LENGTH: cfg_d.slice_length = pwdata[11:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_orders   <= MAX_ORDERS_RST;
      cfg_q.slice_length <= SLICE_LENGTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data is the addressed register, zero-extended.
  always_comb begin
    unique case (reg_idx)
      REG_MAX_ORDERS:   prdata = 32'(cfg_q.max_orders);
      REG_SLICE_LENGTH: prdata = 32'(cfg_q.slice_length);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### design/round_robin_service_queue.sv
// ============================================================================
// round_robin_service_queue
// Bounded circular queue of entries kept in a synchronous RAM, with enqueue,
// dequeue, round-robin run with a time quantum, and find by rating.
// ============================================================================
// Enqueue, full, empty and not-found results load from the start state and a
// dequeue from the execute state; a run passes start and execute per slice and
// ends in start, a find does so per entry examined and ends in start on a miss
// (one RAM read, one execute each). One request is in flight at a time; the
// next is accepted the cycle after the last result loads. Reset clears the
// head, fill count, controller and output valid, but not the entry RAM.
`default_nettype none

module round_robin_service_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire rrsq_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output rrsq_pkg::res_t     out_res_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rrsq_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_START = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  // Reduce a sum below twice the depth to a slot index.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
    logic [CNT_W:0] r;
    r = (s >= DEPTH_EXT) ? (s - DEPTH_EXT) : s;
    return r[IDX_W-1:0];
  endfunction

  // Configuration registers.
  cfg_t cfg;

  rrsq_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e                  state_q, state_d;
  req_t                    req_q, req_d;
  logic [IDX_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic [CNT_W-1:0]        pos_q, pos_d;
  logic signed [12:0]      budget_q, budget_d;
  logic [SLICE_CNT_W-1:0]  n_q, n_d;
  logic                    out_valid_q, out_valid_d;
  res_t                    out_q, out_d;

  logic                    out_free;
  logic                    emit;
  res_t                    res;
  entry_t                  cur;
  logic [IDX_W-1:0]        tail_idx, find_idx, head_inc;

  // Entry RAM ports.
  logic                    rd_en, wr_en;
  logic [IDX_W-1:0]        rd_addr, wr_addr;
  entry_t                  wr_data;
  entry_t                  rd_data_q;
  entry_t                  mem [QUEUE_DEPTH];

  assign out_free = !out_valid_q || !out_stall_i;
  assign tail_idx = wrap_idx((CNT_W + 1)'(head_q) + (CNT_W + 1)'(fill_q));
  assign find_idx = wrap_idx((CNT_W + 1)'(head_q) + (CNT_W + 1)'(pos_q));
  assign head_inc = wrap_idx((CNT_W + 1)'(head_q) + (CNT_W + 1)'(1'b1));
  assign cur      = rd_data_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Request sequencer: read an entry where the operation needs one, then act on it, write back where needed and report.
  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    head_d   = head_q;
    fill_d   = fill_q;
    pos_d    = pos_q;
    budget_d = budget_q;
    n_d      = n_q;
    rd_en    = 1'b0;
    rd_addr  = head_q;
    wr_en    = 1'b0;
    wr_addr  = tail_idx;
    wr_data  = cur;
    emit     = 1'b0;
    res      = '0;
    res.last = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_req_i;
          budget_d = $signed({1'b0, in_req_i.time_budget});
          n_d      = '0;
          pos_d    = '0;
          state_d  = S_START;
        end
      end

      S_START: begin
        unique case (req_q.operation)
          OP_ENQUEUE: begin
            if (out_free) begin
              emit = 1'b1;
              if (fill_q == DEPTH_CNT) begin
                res.status = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = tail_idx;
                wr_data.id     = req_q.driver_id;
                wr_data.rating = req_q.rating;
                wr_data.orders = req_q.orders_done;
                fill_d         = fill_q + 1'b1;
                res.status     = ST_OK;
                res.out_id     = req_q.driver_id;
                res.out_rating = req_q.rating;
                res.out_orders = req_q.orders_done;
              end
              state_d = S_IDLE;
            end
          end
          OP_DEQUEUE: begin
            if (fill_q == '0) begin
              if (out_free) begin
                emit       = 1'b1;
                res.status = ST_EMPTY;
                state_d    = S_IDLE;
              end
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q;
              state_d = S_EXEC;
            end
          end
          OP_RUN: begin
            if (fill_q == '0 || budget_q <= 13'sd0 || n_q == RUN_SLICE_CAP) begin
              if (out_free) begin
                emit       = 1'b1;
                res.status = (fill_q == '0) ? ST_EMPTY : ST_TIMEUP;
                state_d    = S_IDLE;
              end
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q;
              state_d = S_EXEC;
            end
          end
          OP_FIND: begin
            if (pos_q == fill_q) begin
              if (out_free) begin
                emit       = 1'b1;
                res.status = ST_NOT_FOUND;
                state_d    = S_IDLE;
              end
            end else begin
              rd_en   = 1'b1;
              rd_addr = find_idx;
              state_d = S_EXEC;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_EXEC: begin
        unique case (req_q.operation)
          OP_DEQUEUE: begin
            if (out_free) begin
              emit           = 1'b1;
              head_d         = head_inc;
              fill_d         = fill_q - 1'b1;
              res.status     = ST_OK;
              res.out_id     = cur.id;
              res.out_rating = cur.rating;
              res.out_orders = cur.orders;
              state_d        = S_IDLE;
            end
          end
          OP_RUN: begin
            if (out_free) begin
              emit           = 1'b1;
              res.last       = 1'b0;
              res.status     = ST_OK;
              res.out_id     = cur.id;
              res.out_rating = cur.rating;
              head_d         = head_inc;
              // Below the threshold the entry rotates to the tail, else it retires.
              if (cur.orders < cfg.max_orders) begin
                wr_en          = 1'b1;
                wr_addr        = tail_idx;
                wr_data        = cur;
                wr_data.orders = cur.orders + 1'b1;
                res.out_orders = cur.orders + 1'b1;
              end else begin
                fill_d         = fill_q - 1'b1;
                res.out_orders = cur.orders;
                res.retired    = 1'b1;
              end
              budget_d = budget_q - $signed({1'b0, cfg.slice_length});
              n_d      = n_q + 1'b1;
              state_d  = S_START;
            end
          end
          OP_FIND: begin
            if (cur.rating <= req_q.rating) begin
              if (out_free) begin
                emit           = 1'b1;
                res.status     = ST_OK;
                res.out_id     = cur.id;
                res.out_rating = cur.rating;
                res.out_orders = cur.orders;
                res.position   = 4'(pos_q);
                state_d        = S_IDLE;
              end
            end else begin
              pos_d   = pos_q + 1'b1;
              state_d = S_START;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      default: state_d = S_IDLE;
    endcase

    res.entry_count = 5'(fill_d);
  end

  // Output register: loaded by the sequencer, cleared when taken.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and per-request working registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    pos_q    <= pos_d;
    budget_q <= budget_d;
    n_q      <= n_d;
    out_q    <= out_d;
  end

  // Entry RAM, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // The queue never holds more entries than it has slots.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_CNT)
    else $error("fill count exceeds queue depth");

  // The fill count moves by at most one entry per cycle.
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (fill_q == $past(fill_q) || fill_q == $past(fill_q) + 1'b1 ||
              fill_q == $past(fill_q) - 1'b1))
    else $error("fill count jumped by more than one");

  // RAM writes come only from an enqueue or a rotating run slice.
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((state_q == S_START && req_q.operation == OP_ENQUEUE) ||
               (state_q == S_EXEC && req_q.operation == OP_RUN)))
    else $error("entry RAM written outside enqueue or run");

  // A result is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("pending result overwritten");

  // Execution always follows a RAM read issued in the previous cycle.
  a_read_before_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && $past(state_q) != S_EXEC) |-> $past(rd_en))
    else $error("entry used without a preceding read");

endmodule

`default_nettype wire
